### hdl/bitmap_extent_allocator_defines.svh
// ----------------------------------------------------------------------------
// bitmap extent allocator assertion macros
// shared concurrent assertion forms, clocked on clk and gated by arst_n
// ----------------------------------------------------------------------------
`ifndef BITMAP_EXTENT_ALLOCATOR_DEFINES_SVH
`define BITMAP_EXTENT_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BEA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap extent allocator check failed");

// antecedent implies consequent in the following cycle
`define BEA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap extent allocator check failed");

`endif

### hdl/bea_pkg.sv
// ----------------------------------------------------------------------------
// bitmap extent allocator package
// shared constants, codes and types
// ----------------------------------------------------------------------------
package bea_pkg;

	localparam int MAP_BLOCKS_DEF  = 4096;
	localparam int EXT_LIMIT_DEF   = 3;
	localparam int SCAN_ORIGIN     = 6;
	localparam int WORD_BITS       = 32;
	localparam int START_W         = 12;
	localparam int COUNT_W         = 13;
	localparam int STATUS_W        = 2;
	localparam int IN_DATA_W       = 40;
	localparam int OUT_DATA_W      = 32;

	localparam logic [WORD_BITS-1:0] RESET_WORD0 = 32'h0000_003F;
	localparam logic [COUNT_W-1:0]   TOTAL_RESET = 13'd4096;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_MIN     = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
	} word_res_t;

endpackage

### hdl/bea_map_ram.sv
// ----------------------------------------------------------------------------
// bitmap word memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bea_map_ram #(
	parameter int WORDS = 128,
	parameter int AW    = 7
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [bea_pkg::WORD_BITS-1:0]  wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [bea_pkg::WORD_BITS-1:0]  rdata
);
	import bea_pkg::*;

	logic [WORD_BITS-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/bea_word_unit.sv
// ----------------------------------------------------------------------------
// bitmap word unit
// first-bit search from an offset and bit range mask for one map word
// ----------------------------------------------------------------------------
module bea_word_unit (
	input  logic [bea_pkg::WORD_BITS-1:0] word,
	input  logic                          find_used,
	input  logic [4:0]                    from_bit,
	input  logic [4:0]                    mask_lo,
	input  logic [5:0]                    mask_hi,
	output bea_pkg::word_res_t            res,
	output logic [bea_pkg::WORD_BITS-1:0] mask
);
	import bea_pkg::*;

	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS:0]   hi_m;
	logic [WORD_BITS-1:0] lo_m;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			cand[i] = (word[i] == find_used) && (5'(i) >= from_bit);
		end
		res.found = |cand;
		res.idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				res.idx = 5'(i);
			end
		end
	end

	always_comb begin
		hi_m = (33'd1 << mask_hi) - 33'd1;
		lo_m = (32'd1 << mask_lo) - 32'd1;
		mask = hi_m[WORD_BITS-1:0] & ~lo_m;
	end

endmodule

### hdl/bitmap_extent_allocator.sv
// ----------------------------------------------------------------------------
// bitmap extent allocator
// first-fit free-space allocator over a block bitmap, up to EXT_LIMIT
// extents per request, with run release
// ----------------------------------------------------------------------------
// After reset the map memory is swept once, one word per cycle, over all
// MAP_WORDS words before the first item is taken. One item is handled at a
// time. Each map access is a read of one 32-bit word followed by its
// evaluation or write, on the single map memory. A release reads and
// rewrites each word touched and then gives one result. An allocate reads
// each word it scans, where a word is read again for each free run that
// starts in it and each run end found in it, takes a decision step for each
// free run found and a setup step for each extent, reads and rewrites each
// word marked and then gives its results; a fragmented map with many short
// runs makes the scan reread words often.
// ----------------------------------------------------------------------------
module bitmap_extent_allocator #(
	parameter int MAP_BLOCKS = bea_pkg::MAP_BLOCKS_DEF,
	parameter int EXT_LIMIT  = bea_pkg::EXT_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bea_pkg::IN_DATA_W-1:0]   s_tdata,  // first block, block count, minimum size
	input  logic                            s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bea_pkg::OUT_DATA_W-1:0]  m_tdata,  // extent_start, extent_length, status
	output logic                            m_tlast,  // last
	input  logic                            cfg_wen,
	input  logic [bea_pkg::COUNT_W-1:0]     cfg_wdata // total_blocks
);
	import bea_pkg::*;

	`include "bitmap_extent_allocator_defines.svh"

	localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WW  = $clog2(MAP_WORDS);
	localparam int PW  = $clog2(MAP_BLOCKS) + 1;
	localparam int NW  = (PW > COUNT_W) ? PW : COUNT_W;
	localparam int EW  = NW + 1;
	localparam int KW  = (EXT_LIMIT > 1) ? $clog2(EXT_LIMIT) : 1;
	localparam int KCW = $clog2(EXT_LIMIT + 1);

	typedef enum logic [10:0] {
		S_CLEAR     = 11'b000_0000_0001,
		S_IDLE      = 11'b000_0000_0010,
		S_FREE_RD   = 11'b000_0000_0100,
		S_FREE_EV   = 11'b000_0000_1000,
		S_USED_RD   = 11'b000_0001_0000,
		S_USED_EV   = 11'b000_0010_0000,
		S_DECIDE    = 11'b000_0100_0000,
		S_MARK_INIT = 11'b000_1000_0000,
		S_MARK_RD   = 11'b001_0000_0000,
		S_MARK_WR   = 11'b010_0000_0000,
		S_OUT       = 11'b100_0000_0000
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   total_q;
	logic [WW-1:0]        clr_q;
	logic [PW-1:0]        n_q;
	logic [START_W-1:0]   first_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   mn_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        begin_q;
	logic [PW-1:0]        lim_q;
	logic [PW-1:0]        end_q;
	logic [KCW-1:0]       k_q;
	logic [KW-1:0]        mi_q;
	logic [KW-1:0]        ei_q;
	logic [WW-1:0]        word_q;
	logic [PW-1:0]        rlo_q;
	logic [PW-1:0]        rhi_q;
	logic                 set_q;
	logic                 rel_q;
	status_t              status_q;
	logic [PW-1:0]        st_q [EXT_LIMIT];
	logic [COUNT_W-1:0]   ln_q [EXT_LIMIT];

	logic                 mem_we;
	logic [WW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [WW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	word_res_t            wres;
	logic [WORD_BITS-1:0] wmask;
	logic [4:0]           mlo;
	logic [5:0]           mhi;
	logic [WW-1:0]        last_w;
	logic [PW-1:0]        rhi_m1;

	logic [START_W-1:0]   in_first;
	logic [COUNT_W-1:0]   in_cnt;
	logic [COUNT_W-1:0]   in_mn;
	logic [COUNT_W-1:0]   mn_eff;
	logic [PW-1:0]        n_eff;
	logic [EW-1:0]        rel_end;
	logic [PW-1:0]        cand;
	logic [EW-1:0]        next_base;
	logic [EW-1:0]        lim_sum;
	logic [EW-1:0]        lim_eff;
	logic [EW-1:0]        used_pos;
	logic [PW-1:0]        run_len;
	logic [COUNT_W-1:0]   rem_new;
	logic                 out_last;

	assign in_first = s_tdata[11:0];
	assign in_cnt   = s_tdata[24:12];
	assign in_mn    = s_tdata[37:25];
	assign mn_eff   = (in_mn == '0) ? COUNT_W'(1) : in_mn;
	assign n_eff    = (EW'(total_q) < EW'(MAP_BLOCKS)) ? PW'(total_q) : PW'(MAP_BLOCKS);
	assign rel_end  = ((EW'(in_first) + EW'(in_cnt)) < EW'(n_eff)) ?
		(EW'(in_first) + EW'(in_cnt)) : EW'(n_eff);

	assign cand      = {pos_q[PW-1:5], wres.idx};
	assign next_base = EW'({pos_q[PW-1:5], 5'd0}) + EW'(WORD_BITS);
	assign lim_sum   = EW'(cand) + EW'(rem_q);
	assign lim_eff   = (lim_sum < EW'(n_q)) ? lim_sum : EW'(n_q);
	assign used_pos  = wres.found ? EW'(cand) : next_base;
	assign run_len   = end_q - begin_q;
	assign rem_new   = rem_q - COUNT_W'(run_len);

	assign rhi_m1 = rhi_q - PW'(1);
	assign last_w = WW'(rhi_m1 >> 5);
	assign mlo    = (word_q == WW'(rlo_q >> 5)) ? rlo_q[4:0] : 5'd0;
	assign mhi    = (word_q == last_w) ? (6'(rhi_m1[4:0]) + 6'd1) : 6'(WORD_BITS);

	always_comb begin
		mem_re    = (state_q == S_FREE_RD) || (state_q == S_USED_RD) ||
			(state_q == S_MARK_RD);
		mem_raddr = (state_q == S_MARK_RD) ? word_q : WW'(pos_q >> 5);
		mem_we    = (state_q == S_CLEAR) || (state_q == S_MARK_WR);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : word_q;
		if (state_q == S_CLEAR) begin
			mem_wdata = (clr_q == '0) ? RESET_WORD0 : '0;
		end else if (set_q) begin
			mem_wdata = mem_rdata | wmask;
		end else begin
			mem_wdata = mem_rdata & ~wmask;
		end
	end

	bea_map_ram #(
		.WORDS (MAP_WORDS),
		.AW    (WW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bea_word_unit u_unit (
		.word      (mem_rdata),
		.find_used (state_q == S_USED_EV),
		.from_bit  (pos_q[4:0]),
		.mask_lo   (mlo),
		.mask_hi   (mhi),
		.res       (wres),
		.mask      (wmask)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && run_len >= PW'(mn_q) && EW'(run_len) >= EW'(mn_q)) begin
			st_q[k_q[KW-1:0]] <= begin_q;
			ln_q[k_q[KW-1:0]] <= COUNT_W'(run_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			total_q  <= TOTAL_RESET;
			clr_q    <= '0;
			n_q      <= '0;
			first_q  <= '0;
			rem_q    <= '0;
			mn_q     <= '0;
			pos_q    <= '0;
			begin_q  <= '0;
			lim_q    <= '0;
			end_q    <= '0;
			k_q      <= '0;
			mi_q     <= '0;
			ei_q     <= '0;
			word_q   <= '0;
			rlo_q    <= '0;
			rhi_q    <= '0;
			set_q    <= 1'b0;
			rel_q    <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cfg_wen) begin
				total_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WW'(1);
					if (clr_q == WW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						n_q      <= n_eff;
						first_q  <= in_first;
						ei_q     <= '0;
						k_q      <= '0;
						status_q <= ST_OK;
						rel_q    <= s_tuser;
						if (s_tuser) begin
							if (rel_end > EW'(in_first)) begin
								rlo_q   <= PW'(in_first);
								rhi_q   <= PW'(rel_end);
								word_q  <= WW'(in_first >> 5);
								set_q   <= 1'b0;
								state_q <= S_MARK_RD;
							end else begin
								state_q <= S_OUT;
							end
						end else if (mn_eff > in_cnt) begin
							status_q <= ST_MIN;
							state_q  <= S_OUT;
						end else begin
							rem_q <= in_cnt;
							mn_q  <= mn_eff;
							pos_q <= PW'(SCAN_ORIGIN);
							set_q <= 1'b1;
							if (EW'(SCAN_ORIGIN) >= EW'(n_eff)) begin
								status_q <= ST_NOSPACE;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_FREE_RD;
							end
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_EV;
				end
				S_FREE_EV: begin
					if (wres.found) begin
						if (cand >= n_q) begin
							status_q <= ST_NOSPACE;
							state_q  <= S_OUT;
						end else begin
							begin_q <= cand;
							lim_q   <= PW'(lim_eff);
							if (EW'(cand) + EW'(1) >= lim_eff) begin
								end_q   <= cand + PW'(1);
								state_q <= S_DECIDE;
							end else begin
								pos_q   <= cand + PW'(1);
								state_q <= S_USED_RD;
							end
						end
					end else if (next_base >= EW'(n_q)) begin
						status_q <= ST_NOSPACE;
						state_q  <= S_OUT;
					end else begin
						pos_q   <= PW'(next_base);
						state_q <= S_FREE_RD;
					end
				end
				S_USED_RD: begin
					state_q <= S_USED_EV;
				end
				S_USED_EV: begin
					if (wres.found || used_pos >= EW'(lim_q)) begin
						end_q   <= (used_pos < EW'(lim_q)) ? PW'(used_pos) : lim_q;
						state_q <= S_DECIDE;
					end else begin
						pos_q   <= PW'(used_pos);
						state_q <= S_USED_RD;
					end
				end
				S_DECIDE: begin
					pos_q <= end_q;
					if (EW'(run_len) < EW'(mn_q)) begin
						if (end_q >= n_q) begin
							status_q <= ST_NOSPACE;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_FREE_RD;
						end
					end else begin
						k_q   <= k_q + KCW'(1);
						rem_q <= rem_new;
						if ((k_q + KCW'(1) == KCW'(EXT_LIMIT)) || (rem_new == '0)) begin
							mi_q    <= '0;
							state_q <= S_MARK_INIT;
						end else if (end_q >= n_q) begin
							status_q <= ST_NOSPACE;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_FREE_RD;
						end
					end
				end
				S_MARK_INIT: begin
					rlo_q   <= st_q[mi_q];
					rhi_q   <= st_q[mi_q] + PW'(ln_q[mi_q]);
					word_q  <= WW'(st_q[mi_q] >> 5);
					state_q <= S_MARK_RD;
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (word_q == last_w) begin
						if (set_q && (KCW'(mi_q) + KCW'(1) != k_q)) begin
							mi_q    <= mi_q + KW'(1);
							state_q <= S_MARK_INIT;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						word_q  <= word_q + WW'(1);
						state_q <= S_MARK_RD;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						if (out_last) begin
							state_q <= S_IDLE;
						end else begin
							ei_q <= ei_q + KW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_last = rel_q || (status_q != ST_OK) || (KCW'(ei_q) + KCW'(1) == k_q);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tlast  = out_last;

	always_comb begin
		m_tdata = '0;
		if (rel_q) begin
			m_tdata[11:0] = first_q;
		end else if (status_q == ST_OK) begin
			m_tdata[11:0]  = START_W'(st_q[ei_q]);
			m_tdata[24:12] = ln_q[ei_q];
		end
		m_tdata[26:25] = status_q;
	end

	`BEA_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
	`BEA_ASSERT_SAME(a_ready_no_result, s_tready, !m_tvalid)
	`BEA_ASSERT_SAME(a_extent_count, 1'b1, k_q <= KCW'(EXT_LIMIT))
	`BEA_ASSERT_SAME(a_write_when_busy, mem_we, !s_tready)

endmodule
